// ===== hw/rtl/asp_pkg.sv =====
// shared types and constants for the accelerometer slope block
// no dependencies; imported by every module of the block
package asp_pkg;

  localparam int LimW  = 14;
  localparam int OutW  = 15;
  localparam int R2W   = 32;
  localparam int NumW  = 29;
  localparam int Num2W = 58;
  localparam int CandW = 60;
  localparam int QrW   = 46;
  localparam int LsqW  = 29;

  localparam logic [LimW-1:0] SCALE       = 14'd10000;
  localparam logic [LimW-1:0] LIMIT_RESET = 14'd10000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] slope_centi;
    logic                   clamped;
  } out_t;

  // front end to search
  typedef struct packed {
    logic              neg;
    logic [LimW-1:0]   lim;
    logic [R2W-1:0]    r2;
    logic [Num2W-1:0]  num2;
    logic [CandW-1:0]  climit;
  } frt_t;

  // one bit stage of the quotient search
  typedef struct packed {
    logic              neg;
    logic              done;
    logic              clamped;
    logic [LimW-1:0]   q;
    logic [R2W-1:0]    r2;
    logic [Num2W-1:0]  num2;
    logic [Num2W-1:0]  p;
    logic [QrW-1:0]    qr;
  } srch_t;

endpackage

// ===== hw/rtl/asp_front.sv =====
// front end: squares, radius squared, scaled numerator and clamp bound
// depends on asp_pkg
module asp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  asp_pkg::in_t     in_data,
  input  logic [13:0]      lim,
  output logic             fr_valid,
  output asp_pkg::frt_t    fr_data
);
  import asp_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic [30:0]         xsq1_r, zsq1_r;
  logic [15:0]         ymag1_r;
  logic                neg1_r, neg2_r;
  logic [LimW-1:0]     lim1_r, lim2_r;
  logic [LsqW-1:0]     lsq1_r, lsq2_r;
  logic [R2W-1:0]      r2_2_r;
  logic [NumW-1:0]     num2_r;
  frt_t                fr3_r;

  logic signed [31:0]  xp, zp;
  logic [LimW:0]       lp1;
  logic [2*LimW+1:0]   lsq_full;
  logic [15:0]         ymag;
  logic [29:0]         num_full;
  logic [2*NumW-1:0]   num2_full;
  logic [LsqW+R2W-1:0] clim_full;

  always_comb begin
    xp        = in_data.accel_x * in_data.accel_x;
    zp        = in_data.accel_z * in_data.accel_z;
    ymag      = in_data.accel_y[15] ? 16'(-in_data.accel_y) : 16'(in_data.accel_y);
    lp1       = {1'b0, lim} + 15'd1;
    lsq_full  = lp1 * lp1;
    num_full  = ymag1_r * SCALE;
    num2_full = num2_r * num2_r;
    clim_full = lsq2_r * r2_2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    xsq1_r  <= xp[30:0];
    zsq1_r  <= zp[30:0];
    ymag1_r <= ymag;
    neg1_r  <= in_data.accel_y[15];
    lim1_r  <= lim;
    lsq1_r  <= lsq_full[LsqW-1:0];

    r2_2_r  <= {1'b0, xsq1_r} + {1'b0, zsq1_r};
    num2_r  <= num_full[NumW-1:0];
    neg2_r  <= neg1_r;
    lim2_r  <= lim1_r;
    lsq2_r  <= lsq1_r;

    fr3_r.neg    <= neg2_r;
    fr3_r.lim    <= lim2_r;
    fr3_r.r2     <= r2_2_r;
    fr3_r.num2   <= num2_full[Num2W-1:0];
    fr3_r.climit <= clim_full[CandW-1:0];
  end

  assign fr_valid = v3_r;
  assign fr_data  = fr3_r;

endmodule

// ===== hw/rtl/asp_search.sv =====
// clamp decision and one quotient bit per stage, largest q with q*q*r2 <= num2
// depends on asp_pkg
module asp_search (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fr_valid,
  input  asp_pkg::frt_t           fr_data,
  output logic                    sr_valid,
  output logic                    sr_neg,
  output logic                    sr_clamped,
  output logic [asp_pkg::LimW-1:0] sr_mag
);
  import asp_pkg::*;

  srch_t st_r [0:LimW];
  logic  v_r  [0:LimW];
  srch_t st0_nxt;
  logic  r2zero, yzero, over;

  always_comb begin
    r2zero  = (fr_data.r2 == '0);
    yzero   = (fr_data.num2 == '0);
    over    = (fr_data.climit <= CandW'(fr_data.num2));
    st0_nxt = '0;
    st0_nxt.neg  = fr_data.neg;
    st0_nxt.r2   = fr_data.r2;
    st0_nxt.num2 = fr_data.num2;
    if (r2zero) begin
      st0_nxt.done    = 1'b1;
      st0_nxt.clamped = !yzero;
      st0_nxt.q       = yzero ? '0 : fr_data.lim;
    end else if (over) begin
      st0_nxt.done    = 1'b1;
      st0_nxt.clamped = 1'b1;
      st0_nxt.q       = fr_data.lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= fr_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  for (genvar i = 0; i < LimW; i++) begin : g_bit
    localparam int B = LimW - 1 - i;
    srch_t            cur;
    srch_t            nxt;
    logic [CandW-1:0] cand;

    always_comb begin
      cur  = st_r[i];
      nxt  = cur;
      cand = CandW'(cur.p) + (CandW'(cur.qr) << (B + 1)) + (CandW'(cur.r2) << (2 * B));
      if (!cur.done && cand <= CandW'(cur.num2)) begin
        nxt.q[B] = 1'b1;
        nxt.p    = cand[Num2W-1:0];
        nxt.qr   = cur.qr + (QrW'(cur.r2) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      st_r[i+1] <= nxt;
    end
  end

  assign sr_valid   = v_r[LimW];
  assign sr_neg     = st_r[LimW].neg;
  assign sr_clamped = st_r[LimW].clamped;
  assign sr_mag     = st_r[LimW].q;

endmodule

// ===== hw/rtl/accel_slope_percent.sv =====
// top level of the accelerometer slope block: limit register, pipeline, result register
// depends on asp_pkg, asp_front, asp_search
//
// usage
//   a sample transfers on a rising edge with start high and busy low; busy is
//   always low, so one sample may be given every cycle
//   the result (slope in hundredths of a percent, clamp flag) shows on out_data
//   with out_valid high for exactly one cycle, once the sample has passed the
//   stages below; results leave in sample order, one per sample
//   the pipeline holds three front stages (squares, sum and scale, wide
//   products), one clamp decision stage, fourteen quotient bit stages and
//   the output register; throughput is one sample per cycle
//   cfg_we writes cfg_wdata into the slope limit; write only with no sample
//   in flight
//   synchronous reset clears the pipeline valid bits and out_valid and sets
//   the limit to 10000; samples in flight are dropped
//   the receiver cannot stall, every result is taken in its one cycle
module accel_slope_percent (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  asp_pkg::in_t    in_data,
  output logic            out_valid,
  output asp_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [13:0]     cfg_wdata
);
  import asp_pkg::*;

  logic [LimW-1:0] slope_limit_r;
  logic            fr_valid;
  frt_t            fr_data;
  logic            sr_valid, sr_neg, sr_clamped;
  logic [LimW-1:0] sr_mag;
  logic            out_valid_r;
  out_t            out_data_r;
  out_t            out_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      slope_limit_r <= cfg_wdata;
    end
  end

  asp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & !busy),
    .in_data  (in_data),
    .lim      (slope_limit_r),
    .fr_valid (fr_valid),
    .fr_data  (fr_data)
  );

  asp_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .fr_valid   (fr_valid),
    .fr_data    (fr_data),
    .sr_valid   (sr_valid),
    .sr_neg     (sr_neg),
    .sr_clamped (sr_clamped),
    .sr_mag     (sr_mag)
  );

  always_comb begin
    out_nxt.slope_centi = sr_neg ? OutW'(-{1'b0, sr_mag}) : OutW'({1'b0, sr_mag});
    out_nxt.clamped     = sr_clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sr_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
